// File: src/slist_pkg.sv
`default_nettype none
package slist_pkg;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_READ   = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_REMOVE = 2'd1;
	localparam logic [1:0] REQ_READ   = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_BAD_INDEX = 2'd3;

	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [31:0] value;
		logic [3:0]         position;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] read_value;
		logic [4:0]         entry_count;
	} rsp_t;

	typedef struct packed {
		op_t                op;
		logic signed [31:0] value;
		logic [3:0]         position;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_q_t;

	typedef enum logic [2:0] {
		BS_IDLE,
		BS_INS_CMP,
		BS_INS_PUT,
		BS_REM_CMP,
		BS_SH_WR,
		BS_RD_OUT
	} bst_t;

endpackage
`default_nettype wire

// File: src/slist_front.sv
`default_nettype none
module slist_front (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	output logic             busy,
	input  slist_pkg::req_t  req,
	output slist_pkg::cmd_q_t cq,
	input  wire              take
);

	slist_pkg::cmd_t ent_q [2];
	logic            wr_q;
	logic            rd_q;
	logic [1:0]      n_q;
	logic            push;
	logic            pop;
	slist_pkg::cmd_t cls;

	// classify the request before it is queued
	always_comb begin
		cls.value    = req.value;
		cls.position = req.position;
		unique case (req.req_type)
			slist_pkg::REQ_INSERT: cls.op = slist_pkg::OP_INSERT;
			slist_pkg::REQ_REMOVE: cls.op = slist_pkg::OP_REMOVE;
			slist_pkg::REQ_READ:   cls.op = slist_pkg::OP_READ;
			default:               cls.op = slist_pkg::OP_NOP;
		endcase
	end

	assign busy     = (n_q == 2'd2);
	assign push     = start && !busy;
	assign pop      = take && cq.valid;
	assign cq.valid = (n_q != 2'd0);
	assign cq.cmd   = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			n_q  <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			n_q <= n_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule
`default_nettype wire

// File: src/slist_back.sv
`default_nettype none
module slist_back #(
	parameter int DEPTH = 16
) (
	input  wire               clk,
	input  wire               arst_n,
	input  slist_pkg::cmd_q_t cq,
	output logic              take,
	output logic              done,
	output slist_pkg::rsp_t   rsp
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = CW + 1;
	localparam int PW = (CW > 4) ? CW : 4;

	logic signed [31:0] mem [DEPTH];
	logic signed [31:0] rdata_q;

	slist_pkg::bst_t st_q, st_d;
	slist_pkg::cmd_t cmd_q;
	logic [CW-1:0]   cnt_q, cnt_d;
	logic [AW-1:0]   k_q, k_d;
	logic            we;
	logic [AW-1:0]   waddr, raddr;
	logic signed [31:0] wdata;
	logic            fin;
	logic [1:0]      fst;
	logic signed [31:0] frd;
	logic [CW+4:0]   cnt_ext;
	logic [XW-1:0]   k_p1, k_p2, cnt_x;

	assign take  = (st_q == slist_pkg::BS_IDLE);
	assign k_p1  = XW'(k_q) + XW'(1);
	assign k_p2  = XW'(k_q) + XW'(2);
	assign cnt_x = XW'(cnt_q);

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	always_comb begin
		st_d  = st_q;
		cnt_d = cnt_q;
		k_d   = k_q;
		we    = 1'b0;
		waddr = k_q;
		wdata = cmd_q.value;
		raddr = k_q;
		fin   = 1'b0;
		fst   = slist_pkg::ST_OK;
		frd   = '0;
		unique case (st_q)
			slist_pkg::BS_IDLE: begin
				if (cq.valid) begin
					unique case (cq.cmd.op)
						slist_pkg::OP_INSERT: begin
							if (cnt_q >= CW'(DEPTH)) begin
								fin = 1'b1;
								fst = slist_pkg::ST_FULL;
							end else if (cnt_q == '0) begin
								st_d = slist_pkg::BS_INS_PUT;
							end else begin
								k_d   = cnt_q[AW-1:0];
								raddr = cnt_q[AW-1:0] - AW'(1);
								st_d  = slist_pkg::BS_INS_CMP;
							end
						end
						slist_pkg::OP_REMOVE: begin
							if (cnt_q == '0) begin
								fin = 1'b1;
								fst = slist_pkg::ST_NOT_FOUND;
							end else begin
								k_d   = '0;
								raddr = '0;
								st_d  = slist_pkg::BS_REM_CMP;
							end
						end
						slist_pkg::OP_READ: begin
							if (PW'(cq.cmd.position) < PW'(cnt_q)) begin
								raddr = AW'(cq.cmd.position);
								st_d  = slist_pkg::BS_RD_OUT;
							end else begin
								fin = 1'b1;
								fst = slist_pkg::ST_BAD_INDEX;
							end
						end
						default: fin = 1'b1;
					endcase
				end
			end
			slist_pkg::BS_INS_CMP: begin
				// shift larger entries up, stop at the first one not above the value
				we = 1'b1;
				if (rdata_q > cmd_q.value) begin
					wdata = rdata_q;
					k_d   = k_q - AW'(1);
					raddr = k_q - AW'(2);
					if (k_q == AW'(1)) st_d = slist_pkg::BS_INS_PUT;
				end else begin
					fin   = 1'b1;
					cnt_d = cnt_q + CW'(1);
					st_d  = slist_pkg::BS_IDLE;
				end
			end
			slist_pkg::BS_INS_PUT: begin
				we    = 1'b1;
				waddr = '0;
				fin   = 1'b1;
				cnt_d = cnt_q + CW'(1);
				st_d  = slist_pkg::BS_IDLE;
			end
			slist_pkg::BS_REM_CMP: begin
				raddr = k_p1[AW-1:0];
				if (rdata_q == cmd_q.value) begin
					if (k_p1 >= cnt_x) begin
						fin   = 1'b1;
						cnt_d = cnt_q - CW'(1);
						st_d  = slist_pkg::BS_IDLE;
					end else begin
						st_d = slist_pkg::BS_SH_WR;
					end
				end else if (k_p1 >= cnt_x) begin
					fin  = 1'b1;
					fst  = slist_pkg::ST_NOT_FOUND;
					st_d = slist_pkg::BS_IDLE;
				end else begin
					k_d = k_p1[AW-1:0];
				end
			end
			slist_pkg::BS_SH_WR: begin
				// close the gap one entry per cycle
				we    = 1'b1;
				wdata = rdata_q;
				k_d   = k_p1[AW-1:0];
				raddr = k_p2[AW-1:0];
				if (k_p2 >= cnt_x) begin
					fin   = 1'b1;
					cnt_d = cnt_q - CW'(1);
					st_d  = slist_pkg::BS_IDLE;
				end
			end
			slist_pkg::BS_RD_OUT: begin
				fin  = 1'b1;
				frd  = rdata_q;
				st_d = slist_pkg::BS_IDLE;
			end
			default: st_d = slist_pkg::BS_IDLE;
		endcase
	end

	assign cnt_ext = {5'b0, cnt_d};

	always_ff @(posedge clk) begin
		if (take && cq.valid) cmd_q <= cq.cmd;
		k_q <= k_d;
		if (fin) begin
			rsp.status      <= fst;
			rsp.read_value  <= frd;
			rsp.entry_count <= cnt_ext[4:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= slist_pkg::BS_IDLE;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			st_q  <= st_d;
			cnt_q <= cnt_d;
			done  <= fin;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_cnt_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != $past(cnt_q) |-> done)
		else $error("count changed without a result");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status == slist_pkg::ST_FULL |-> cnt_q == CW'(DEPTH))
		else $error("full status while list not full");

	a_busy_back: assert property (@(posedge clk) disable iff (!arst_n)
		st_q != slist_pkg::BS_IDLE |=> !(done && $past(done)))
		else $error("result strobe longer than one cycle");

endmodule
`default_nettype wire

// File: src/sorted_list_insert_remove.sv
`default_nettype none
// Channel   Ports                     Handshake
// request   start, busy, req          taken when start && !busy
// result    done, rsp                 one cycle on done, no back-pressure
//
// Read: the entry is read, then given out. Insert: each larger entry is shifted
// up one slot, then the value is written. Remove: entries are scanned up to a
// match, then later ones shift down; the one-read one-write entry memory with
// registered read sets this. A request refused or ignored at once (insert when
// full, remove when empty, read beyond the count, unused code) ends in idle.
// A two-entry request queue keeps taking requests while the back end works;
// busy rises only when it is full. Reset clears the count; entries need none.
module sorted_list_insert_remove #(
	parameter int DEPTH = 16
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             start,
	output logic            busy,
	input  slist_pkg::req_t req,
	output logic            done,
	output slist_pkg::rsp_t rsp
);

	slist_pkg::cmd_q_t cq;
	logic              take;

	slist_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.cq     (cq),
		.take   (take)
	);

	slist_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cq     (cq),
		.take   (take),
		.done   (done),
		.rsp    (rsp)
	);

endmodule
`default_nettype wire

// File: verif/tb_sorted_list_insert_remove.sv
module tb_sorted_list_insert_remove;

	localparam int LIST_DEPTH = 16;
	localparam int SETTLE_CYCLES = 60;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	slist_pkg::req_t req = '0;
	logic done;
	slist_pkg::rsp_t rsp;

	logic signed [31:0] sorted_mirror [LIST_DEPTH];
	int mirror_count = 0;
	slist_pkg::rsp_t pending_rsp [$];
	slist_pkg::rsp_t oldest_rsp;
	int mismatches = 0;

	sorted_list_insert_remove #(
		.DEPTH(LIST_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	// Apply one request to the mirrored list and return the response it should give.
	function automatic slist_pkg::rsp_t predict_response(slist_pkg::req_t item);
		slist_pkg::rsp_t res;
		int slot;
		int k;
		res.status = slist_pkg::ST_OK;
		res.read_value = '0;
		case (item.req_type)
			slist_pkg::REQ_INSERT: begin
				if (mirror_count >= LIST_DEPTH) begin
					res.status = slist_pkg::ST_FULL;
				end else begin
					// land after every equal entry
					slot = 0;
					while (slot < mirror_count && sorted_mirror[slot] <= item.value)
						slot++;
					for (k = mirror_count; k > slot; k--)
						sorted_mirror[k] = sorted_mirror[k - 1];
					sorted_mirror[slot] = item.value;
					mirror_count++;
				end
			end
			slist_pkg::REQ_REMOVE: begin
				slot = 0;
				while (slot < mirror_count && sorted_mirror[slot] != item.value)
					slot++;
				if (slot >= mirror_count) begin
					res.status = slist_pkg::ST_NOT_FOUND;
				end else begin
					for (k = slot; k + 1 < mirror_count; k++)
						sorted_mirror[k] = sorted_mirror[k + 1];
					mirror_count--;
				end
			end
			slist_pkg::REQ_READ: begin
				if (int'(item.position) < mirror_count)
					res.read_value = sorted_mirror[item.position];
				else
					res.status = slist_pkg::ST_BAD_INDEX;
			end
			default: ;
		endcase
		res.entry_count = 5'(mirror_count);
		return res;
	endfunction

	function automatic slist_pkg::req_t make_req(logic [1:0] kind, logic signed [31:0] v,
		logic [3:0] pos);
		slist_pkg::req_t item;
		item.req_type = kind;
		item.value = v;
		item.position = pos;
		return item;
	endfunction

	// Bias toward extremes and a narrow band so duplicates and removes hit often.
	function automatic logic signed [31:0] pick_value();
		logic signed [31:0] v;
		case ($urandom_range(9))
			0: v = 32'sh8000_0000;
			1: v = 32'sh7FFF_FFFF;
			2, 3, 4: v = $signed(32'($urandom_range(8))) - 32'sd4;
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// bias 0 grows the list, 1 shrinks it, 2 keeps it wandering
	function automatic slist_pkg::req_t random_request(int bias);
		slist_pkg::req_t item;
		int roll;
		int ins_lim;
		int rem_lim;
		roll = $urandom_range(99);
		ins_lim = (bias == 0) ? 65 : (bias == 1) ? 15 : 40;
		rem_lim = (bias == 0) ? 80 : (bias == 1) ? 75 : 70;
		item.value = pick_value();
		item.position = 4'($urandom_range(15));
		if (roll < ins_lim) begin
			item.req_type = slist_pkg::REQ_INSERT;
		end else if (roll < rem_lim) begin
			item.req_type = slist_pkg::REQ_REMOVE;
			if (mirror_count > 0 && $urandom_range(99) < 65)
				item.value = sorted_mirror[$urandom_range(mirror_count - 1)];
		end else if (roll < 96) begin
			item.req_type = slist_pkg::REQ_READ;
		end else begin
			item.req_type = slist_pkg::OP_NOP;
		end
		return item;
	endfunction

	// Hold the request until taken, record its response, then idle for the given gap.
	task automatic send_request(slist_pkg::req_t item, int gap);
		start <= 1'b1;
		req <= item;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_rsp.push_back(predict_response(item));
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_all_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending_rsp.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		send_request(make_req(slist_pkg::REQ_READ, 32'sd0, 4'd0), 0);
		send_request(make_req(slist_pkg::REQ_REMOVE, 32'sd0, 4'd0), 0);
		send_request(make_req(slist_pkg::OP_NOP, 32'sd0, 4'd0), 0);
		send_request(make_req(slist_pkg::REQ_INSERT, 32'sh7FFF_FFFF, 4'd0), 0);
		send_request(make_req(slist_pkg::REQ_INSERT, 32'sh8000_0000, 4'd0), 0);
		send_request(make_req(slist_pkg::REQ_INSERT, 32'sd0, 4'd0), 0);
		send_request(make_req(slist_pkg::REQ_INSERT, -32'sd1, 4'd0), 0);
		send_request(make_req(slist_pkg::REQ_INSERT, 32'sd0, 4'd0), 0);
		send_request(make_req(slist_pkg::REQ_INSERT, 32'sd1, 4'd0), 0);
		send_request(make_req(slist_pkg::REQ_READ, 32'sd0, 4'd0), 0);
		send_request(make_req(slist_pkg::REQ_READ, 32'sd0, 4'd5), 0);
		send_request(make_req(slist_pkg::REQ_READ, 32'sd0, 4'd6), 0);
		send_request(make_req(slist_pkg::REQ_READ, 32'sd0, 4'd15), 0);
		send_request(make_req(slist_pkg::REQ_REMOVE, 32'sd0, 4'd0), 0);
		send_request(make_req(slist_pkg::REQ_REMOVE, 32'sd12345, 4'd0), 0);
		send_request(make_req(slist_pkg::REQ_REMOVE, 32'sh8000_0000, 4'd0), 0);
		send_request(make_req(slist_pkg::REQ_REMOVE, 32'sh7FFF_FFFF, 4'd0), 0);
		send_request(make_req(slist_pkg::REQ_READ, 32'sd0, 4'd2), 0);
		send_request(make_req(slist_pkg::OP_NOP, -32'sd1, 4'd15), 0);
		send_request(make_req(slist_pkg::REQ_INSERT, 32'sh8000_0001, 4'd0), 0);
		send_request(make_req(slist_pkg::REQ_READ, 32'sd0, 4'd0), 0);
	endtask

	task automatic test_random(int count, int idle_pct);
		int bias;
		int gap;
		slist_pkg::req_t item;
		bias = 2;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0)
				bias = $urandom_range(2);
			item = random_request(bias);
			gap = 0;
			// idle each cycle with the given odds
			while (int'($urandom_range(99)) < idle_pct)
				gap++;
			send_request(item, gap);
			if (i % 300 == 299)
				wait_all_results();
		end
	endtask

	always @(posedge clk) begin
		if (done === 1'b1) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t: unexpected result status=%0d read_value=%0d entry_count=%0d",
					$time, rsp.status, rsp.read_value, rsp.entry_count);
				mismatches++;
			end else begin
				oldest_rsp = pending_rsp.pop_front();
				if (rsp.status !== oldest_rsp.status ||
				    rsp.read_value !== oldest_rsp.read_value ||
				    rsp.entry_count !== oldest_rsp.entry_count) begin
					$display("%0t: mismatch expected status=%0d read_value=%0d entry_count=%0d",
						$time, oldest_rsp.status, oldest_rsp.read_value,
						oldest_rsp.entry_count);
					$display("%0t:          actual status=%0d read_value=%0d entry_count=%0d",
						$time, rsp.status, rsp.read_value, rsp.entry_count);
					mismatches++;
				end
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		wait_all_results();
		test_random(700, 0);
		wait_all_results();
		test_random(700, 72);
		wait_all_results();
		test_random(600, 25);
		wait_all_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_rsp.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: sorted_list_insert_remove.f
src/slist_pkg.sv
src/slist_front.sv
src/slist_back.sv
src/sorted_list_insert_remove.sv
verif/tb_sorted_list_insert_remove.sv
